### design/sgm_pkg.sv
`default_nettype none
package sgm_pkg;

    localparam int PIX_W   = 8;
    localparam int CFG_W   = 10;
    localparam int IDX_W   = 2;
    localparam int MAG_W   = 11;
    localparam int POS_W   = 9;
    localparam int GRAD_W  = 11;
    localparam int SQ_W    = 21;
    localparam int ROOT_W  = 23;
    localparam int ROOT_IT = 12;
    localparam int MIN_SIZE = 3;

    localparam logic [CFG_W-1:0] SIZE_RST = 10'd512;

    localparam logic [IDX_W-1:0] REG_WIDTH  = 2'd0;
    localparam logic [IDX_W-1:0] REG_HEIGHT = 2'd1;

    typedef struct packed {
        logic take;
        logic update;
        logic grad;
        logic square;
        logic root_start;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic interior;
        logic root_done;
        logic out_free;
    } sts_t;

endpackage
`default_nettype wire

### design/sobel_gradient_magnitude.sv
// 3x3 Sobel gradient magnitude over a raster-order pixel stream.
// Input: s_valid/s_ready/s_pixel, one grey pixel per transaction.
// Output: m_valid/m_ready with magnitude = floor(sqrt(gx^2+gy^2)), the
// centre row/column and last_of_frame, one transaction per interior pixel.
// Config: cfg_valid/cfg_ready (always ready), cfg_index 0 = width,
// 1 = height, other indexes ignored; write only while idle.
// Sequence: a border pixel is accepted and then only updates the window.
// An interior pixel goes from acceptance to m_valid through update,
// gradient, square, then a 12-step shift-subtract square root, then the
// output register. A new pixel is accepted only once the last one is done.
// Two line stores live in single-port-write RAMs read at the column count.
// A result waits in the output register while m_ready is low; the next
// pixel can be processed meanwhile, but a further result stalls input.
// Reset (aresetn low, synchronous) clears counters, window, the output
// valid and sets width and height to 512; line store contents are kept.
`default_nettype none
module sobel_gradient_magnitude #(
    parameter int MAX_WIDTH  = 512,
    parameter int MAX_HEIGHT = 512
) (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       s_valid,
    output logic                            s_ready,
    input  wire logic [sgm_pkg::PIX_W-1:0]  s_pixel,
    input  wire logic                       cfg_valid,
    output logic                            cfg_ready,
    input  wire logic [sgm_pkg::IDX_W-1:0]  cfg_index,
    input  wire logic [sgm_pkg::CFG_W-1:0]  cfg_data,
    output logic                            m_valid,
    input  wire logic                       m_ready,
    output logic      [sgm_pkg::MAG_W-1:0]  m_magnitude,
    output logic      [sgm_pkg::POS_W-1:0]  m_centre_row,
    output logic      [sgm_pkg::POS_W-1:0]  m_centre_col,
    output logic                            m_last_of_frame
);
    import sgm_pkg::*;

    cmd_t cmd;
    sts_t sts;

    assign cfg_ready = 1'b1;

    sgm_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    sgm_datapath #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_dp (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cmd             (cmd),
        .sts             (sts),
        .s_pixel         (s_pixel),
        .cfg_valid       (cfg_valid),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .m_ready         (m_ready),
        .m_valid         (m_valid),
        .m_magnitude     (m_magnitude),
        .m_centre_row    (m_centre_row),
        .m_centre_col    (m_centre_col),
        .m_last_of_frame (m_last_of_frame)
    );
endmodule
`default_nettype wire

### design/sgm_ram.sv
`default_nettype none
module sgm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 512
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

### design/sgm_isqrt.sv
`default_nettype none
module sgm_isqrt (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       start,
    input  wire logic [sgm_pkg::ROOT_W-1:0] value,
    output logic                            done,
    output logic      [sgm_pkg::MAG_W-1:0]  root
);
    import sgm_pkg::*;

    logic [ROOT_W-1:0] v_reg, v_next;
    logic [ROOT_W-1:0] res_reg, res_next;
    logic [ROOT_W-1:0] bit_reg, bit_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [ROOT_W-1:0] trial;

    assign trial = res_reg + bit_reg;

    always_comb begin
        v_next    = v_reg;
        res_next  = res_reg;
        bit_next  = bit_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            v_next    = value;
            res_next  = '0;
            bit_next  = ROOT_W'(1) << (2 * (ROOT_IT - 1));
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (v_reg >= trial) begin
                v_next   = v_reg - trial;
                res_next = (res_reg >> 1) + bit_reg;
            end else begin
                res_next = res_reg >> 1;
            end
            bit_next = bit_reg >> 2;
            if (bit_reg[0]) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        v_reg   <= v_next;
        res_reg <= res_next;
        bit_reg <= bit_next;
    end

    assign done = done_reg;
    assign root = res_reg[MAG_W-1:0];
endmodule
`default_nettype wire

### design/sgm_datapath.sv
`default_nettype none
module sgm_datapath #(
    parameter int MAX_WIDTH  = 512,
    parameter int MAX_HEIGHT = 512
) (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire sgm_pkg::cmd_t              cmd,
    output sgm_pkg::sts_t                   sts,
    input  wire logic [sgm_pkg::PIX_W-1:0]  s_pixel,
    input  wire logic                       cfg_valid,
    input  wire logic [sgm_pkg::IDX_W-1:0]  cfg_index,
    input  wire logic [sgm_pkg::CFG_W-1:0]  cfg_data,
    input  wire logic                       m_ready,
    output logic                            m_valid,
    output logic      [sgm_pkg::MAG_W-1:0]  m_magnitude,
    output logic      [sgm_pkg::POS_W-1:0]  m_centre_row,
    output logic      [sgm_pkg::POS_W-1:0]  m_centre_col,
    output logic                            m_last_of_frame
);
    import sgm_pkg::*;

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int RW = $clog2(MAX_HEIGHT);

    logic [CFG_W-1:0] width_reg, height_reg;
    int unsigned      w_eff, h_eff, c32, r32;

    logic [CW-1:0]    col_reg, col_next;
    logic [RW-1:0]    row_reg, row_next;
    logic [PIX_W-1:0] pix_reg;
    logic [PIX_W-1:0] up_rd, mid_rd;
    logic [PIX_W-1:0] win_reg [3][3];

    logic signed [GRAD_W-1:0] gx_reg, gy_reg;
    logic [SQ_W-1:0]          sqx_reg, sqy_reg;
    logic [POS_W-1:0]         crow_reg, ccol_reg;
    logic                     last_reg;
    logic [GRAD_W-2:0]        sx_pos, sx_neg, sy_pos, sy_neg;
    logic                     root_done;
    logic [MAG_W-1:0]         root;
    logic                     m_valid_reg;
    logic [MAG_W-1:0]         mag_reg;
    logic [POS_W-1:0]         orow_reg, ocol_reg;
    logic                     olast_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= SIZE_RST;
            height_reg <= SIZE_RST;
        end else if (cfg_valid) begin
            if (cfg_index == REG_WIDTH) begin
                width_reg <= cfg_data;
            end else if (cfg_index == REG_HEIGHT) begin
                height_reg <= cfg_data;
            end
        end
    end

    always_comb begin
        w_eff = 32'(width_reg);
        h_eff = 32'(height_reg);
        if (w_eff < MIN_SIZE) begin
            w_eff = MIN_SIZE;
        end else if (w_eff > MAX_WIDTH) begin
            w_eff = MAX_WIDTH;
        end
        if (h_eff < MIN_SIZE) begin
            h_eff = MIN_SIZE;
        end else if (h_eff > MAX_HEIGHT) begin
            h_eff = MAX_HEIGHT;
        end
        c32 = 32'(col_reg);
        r32 = 32'(row_reg);
    end

    always_comb begin
        col_next = col_reg + CW'(1);
        row_next = row_reg;
        if (c32 + 1 >= w_eff) begin
            col_next = '0;
            row_next = (r32 + 1 >= h_eff) ? '0 : row_reg + RW'(1);
        end
    end

    assign sts.interior = (r32 >= 2) && (r32 < h_eff) && (c32 >= 2) && (c32 < w_eff);

    sgm_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_upper (
        .aclk  (aclk),
        .we    (cmd.update),
        .waddr (col_reg),
        .wdata (mid_rd),
        .raddr (col_reg),
        .rdata (up_rd)
    );

    sgm_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_middle (
        .aclk  (aclk),
        .we    (cmd.update),
        .waddr (col_reg),
        .wdata (pix_reg),
        .raddr (col_reg),
        .rdata (mid_rd)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg <= '0;
            row_reg <= '0;
            for (int k = 0; k < 3; k++) begin
                for (int l = 0; l < 3; l++) begin
                    win_reg[k][l] <= '0;
                end
            end
        end else if (cmd.update) begin
            col_reg <= col_next;
            row_reg <= row_next;
            for (int k = 0; k < 3; k++) begin
                win_reg[k][0] <= win_reg[k][1];
                win_reg[k][1] <= win_reg[k][2];
            end
            win_reg[0][2] <= up_rd;
            win_reg[1][2] <= mid_rd;
            win_reg[2][2] <= pix_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.take) begin
            pix_reg <= s_pixel;
        end
        if (cmd.update) begin
            crow_reg <= POS_W'(r32 - 1);
            ccol_reg <= POS_W'(c32 - 1);
            last_reg <= (r32 == h_eff - 1) && (c32 == w_eff - 1);
        end
    end

    assign sx_pos = 10'(win_reg[0][2]) + {1'b0, win_reg[1][2], 1'b0} + 10'(win_reg[2][2]);
    assign sx_neg = 10'(win_reg[0][0]) + {1'b0, win_reg[1][0], 1'b0} + 10'(win_reg[2][0]);
    assign sy_pos = 10'(win_reg[0][0]) + {1'b0, win_reg[0][1], 1'b0} + 10'(win_reg[0][2]);
    assign sy_neg = 10'(win_reg[2][0]) + {1'b0, win_reg[2][1], 1'b0} + 10'(win_reg[2][2]);

    always_ff @(posedge aclk) begin
        if (cmd.grad) begin
            gx_reg <= $signed({1'b0, sx_pos}) - $signed({1'b0, sx_neg});
            gy_reg <= $signed({1'b0, sy_pos}) - $signed({1'b0, sy_neg});
        end
        if (cmd.square) begin
            sqx_reg <= $unsigned(SQ_W'(gx_reg) * SQ_W'(gx_reg));
            sqy_reg <= $unsigned(SQ_W'(gy_reg) * SQ_W'(gy_reg));
        end
    end

    sgm_isqrt u_isqrt (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cmd.root_start),
        .value   (ROOT_W'(sqx_reg) + ROOT_W'(sqy_reg)),
        .done    (root_done),
        .root    (root)
    );

    assign sts.root_done = root_done;
    assign sts.out_free  = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
        if (cmd.out_load) begin
            mag_reg   <= root;
            orow_reg  <= crow_reg;
            ocol_reg  <= ccol_reg;
            olast_reg <= last_reg;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_magnitude     = mag_reg;
    assign m_centre_row    = orow_reg;
    assign m_centre_col    = ocol_reg;
    assign m_last_of_frame = olast_reg;
endmodule
`default_nettype wire

### design/sgm_ctrl.sv
`default_nettype none
module sgm_ctrl (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          s_valid,
    output logic               s_ready,
    input  wire sgm_pkg::sts_t sts,
    output sgm_pkg::cmd_t      cmd
);
    import sgm_pkg::*;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_UPD  = 3'd1;
    localparam logic [2:0] ST_GRAD = 3'd2;
    localparam logic [2:0] ST_SQR  = 3'd3;
    localparam logic [2:0] ST_SUM  = 3'd4;
    localparam logic [2:0] ST_ROOT = 3'd5;
    localparam logic [2:0] ST_OUT  = 3'd6;

    logic [2:0] state_reg, state_next;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready  = 1'b1;
                cmd.take = s_valid;
                if (s_valid) begin
                    state_next = ST_UPD;
                end
            end
            ST_UPD: begin
                cmd.update = 1'b1;
                state_next = sts.interior ? ST_GRAD : ST_IDLE;
            end
            ST_GRAD: begin
                cmd.grad   = 1'b1;
                state_next = ST_SQR;
            end
            ST_SQR: begin
                cmd.square = 1'b1;
                state_next = ST_SUM;
            end
            ST_SUM: begin
                cmd.root_start = 1'b1;
                state_next     = ST_ROOT;
            end
            ST_ROOT: begin
                if (sts.root_done) begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (sts.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end
endmodule
`default_nettype wire
